FILE: rtl/satellite_azimuth_elevation_top_macros.svh
// Assertion macros shared by the block's checker.
`ifndef SATELLITE_AZIMUTH_ELEVATION_TOP_MACROS_SVH
`define SATELLITE_AZIMUTH_ELEVATION_TOP_MACROS_SVH

// Property that is checked only while reset is released.
`define SAE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that is checked in every cycle, reset included.
`define SAE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sae_pkg.sv
// Shared constants, types and arithmetic helpers of the azimuth and elevation block.
package sae_pkg;

    localparam int ITERS      = 40;
    localparam int TURN_FRAC  = 48;
    localparam int NORM_TOP   = 28;
    localparam int ANGLE_BITS = 32;
    localparam int VW         = 40;
    localparam int AW         = 50;
    localparam int GW         = 36;
    localparam int OUT_SH     = TURN_FRAC - ANGLE_BITS;

    localparam int POS_W  = 34;
    localparam int VEL_W  = 25;
    localparam int LOOK_W = 8;
    localparam int S_DATA_W = 280;
    localparam int M_DATA_W = 64;

    localparam logic [LOOK_W-1:0]    LOOK_RESET = 8'd20;
    localparam logic signed [31:0]   GAIN_Q30   = 32'sd1768195363;
    localparam logic [63:0]          INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [AW-1:0] ang_t;
    typedef ang_t atan_tbl_t [ITERS];

    localparam ang_t ANG_HALF = ang_t'(1) <<< (TURN_FRAC - 1);
    localparam ang_t ANG_QTR  = ang_t'(1) <<< (TURN_FRAC - 2);
    localparam logic signed [AW:0] OUT_RND_A = (AW+1)'(1) <<< (OUT_SH - 1);
    localparam logic signed [AW:0] OUT_RND_B = (AW+1)'(1) <<< 15;

    // atan(2^-i) in 2^-48 turn units, from the integer arctangent series.
    function automatic atan_tbl_t build_atan();
        atan_tbl_t    t;
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        int           e;
        t[0] = ang_t'(1) <<< (TURN_FRAC - 3);
        for (int i = 1; i < ITERS; i++) begin
            sum = '0;
            for (int k = 0; k < 32; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = (64'd1 << e) / 64'(2 * k + 1);
                    if (k % 2 == 1) sum = sum - term;
                    else            sum = sum + term;
                end
            end
            prod = {64'd0, sum} * {64'd0, INV_TWO_PI_Q64};
            t[i] = ang_t'(prod[127:64] >> (62 - TURN_FRAC));
        end
        return t;
    endfunction

    localparam atan_tbl_t ATAN_TBL = build_atan();

    function automatic vec_t rot_x(vec_t x, vec_t y, int sh, logic cw);
        return cw ? x + (y >>> sh) : x - (y >>> sh);
    endfunction

    function automatic vec_t rot_y(vec_t x, vec_t y, int sh, logic cw);
        return cw ? y - (x >>> sh) : y + (x >>> sh);
    endfunction

    // CORDIC gain matching, rounded half up.
    function automatic vec_t gain_k(vec_t v);
        logic signed [GW+31:0] p;
        p = $signed(v[GW-1:0]) * GAIN_Q30;
        p = p + ((GW+32)'(1) <<< 29);
        p = p >>> 30;
        return p[VW-1:0];
    endfunction

    // Round to ANGLE_BITS per turn, then to 2^-32 turn units.
    function automatic logic [31:0] to_output(ang_t a);
        logic signed [AW:0] r;
        r = ($signed({a[AW-1], a}) + OUT_RND_A) >>> OUT_SH;
        r = r <<< OUT_SH;
        r = (r + OUT_RND_B) >>> 16;
        return r[31:0];
    endfunction

endpackage

FILE: rtl/sae_norm.sv
// Three-stage block normalisation of a vector to a top magnitude bit of 28.
module sae_norm #(
    parameter int N = 3
) (
    input  logic         aclk,
    input  logic         adv,
    input  sae_pkg::vec_t vec_i [N],
    output sae_pkg::vec_t vec_o [N]
);
    import sae_pkg::*;

    localparam int SW = $clog2(VW);

    vec_t             v1_reg [N];
    vec_t             v2_reg [N];
    vec_t             vo_reg [N];
    logic [VW-1:0]    or_next;
    logic [VW-1:0]    or_reg;
    logic [SW-1:0]    top_next;
    logic [SW-1:0]    top_reg;
    vec_t             abs_v;

    // The top bit of the largest magnitude is the top bit of the OR of all magnitudes.
    always_comb begin
        or_next = '0;
        abs_v   = '0;
        for (int j = 0; j < N; j++) begin
            abs_v   = vec_i[j][VW-1] ? -vec_i[j] : vec_i[j];
            or_next = or_next | abs_v;
        end
    end

    always_comb begin
        top_next = '0;
        for (int b = 0; b < VW; b++) begin
            if (or_reg[b]) top_next = SW'(b);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v1_reg  <= vec_i;
            or_reg  <= or_next;
            v2_reg  <= v1_reg;
            top_reg <= top_next;
            for (int j = 0; j < N; j++) begin
                if (top_reg < SW'(NORM_TOP))
                    vo_reg[j] <= v2_reg[j] <<< (SW'(NORM_TOP) - top_reg);
                else
                    vo_reg[j] <= v2_reg[j] >>> (top_reg - SW'(NORM_TOP));
            end
        end
    end

    assign vec_o = vo_reg;

endmodule

FILE: rtl/satellite_azimuth_elevation_top.sv
// Top level of the pipelined satellite azimuth and elevation block.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready| satellite position, velocity, receiver
//  m_axis   | out       | m_axis_tvalid/m_axis_tready| elevation, azimuth; tuser degenerate
//  cfg      | in        | cfg_wr_en                  | lookahead_seconds
//
// One transaction is accepted per cycle while the output is not stalled, and each gives
// one result transaction; the pipeline holds four chains of 40 CORDIC stages.
// Reset is synchronous and active low; it clears the valid bits and sets
// lookahead_seconds to 20. A stalled output freezes the whole pipeline in
// place, so nothing is lost or repeated, and the input is still taken
// whenever the output register is empty or being emptied.
module satellite_azimuth_elevation_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sae_pkg::LOOK_W-1:0]    cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // sat_x, sat_y, sat_z, sat_vx, sat_vy, sat_vz, rx_x, rx_y, rx_z, zero pad
    input  logic [sae_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // elevation, azimuth
    output logic [sae_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // degenerate
    output logic                          m_axis_tuser
);
    import sae_pkg::*;

    logic adv;
    logic [LOOK_W-1:0] lookahead_reg;

    // The whole pipeline moves forward together unless the output is held.
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookahead_reg <= LOOK_RESET;
        end else if (cfg_wr_en) begin
            lookahead_reg <= cfg_wr_data;
        end
    end

    // Unpacking of the input transaction.
    logic signed [POS_W-1:0] in_sat [3];
    logic signed [VEL_W-1:0] in_vel [3];
    logic signed [POS_W-1:0] in_rx  [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            in_sat[j] = s_axis_tdata[j*POS_W +: POS_W];
            in_vel[j] = s_axis_tdata[3*POS_W + j*VEL_W +: VEL_W];
            in_rx[j]  = s_axis_tdata[3*POS_W + 3*VEL_W + j*POS_W +: POS_W];
        end
    end

    // Stage 1: position difference and velocity times lookahead.
    logic                             s1_valid_reg;
    logic signed [POS_W:0]            s1_diff_reg [3];
    logic signed [VEL_W+LOOK_W:0]     s1_vt_reg   [3];
    logic signed [POS_W-1:0]          s1_rx_reg   [3];

    // Stage 2: line of sight in millimetres and predicted line of sight.
    logic  s2_valid_reg;
    logic  s2_rxz_reg;
    vec_t  s2_los_reg [3];
    vec_t  s2_pre_reg [3];
    vec_t  s2_rx_reg  [3];
    vec_t  los_next   [3];
    vec_t  pre_next   [3];
    vec_t  de         [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            de[j]       = VW'(s1_diff_reg[j]);
            los_next[j] = (de[j] <<< 3) + (de[j] <<< 1);
            pre_next[j] = los_next[j] + VW'(s1_vt_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_axis_tvalid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                s1_diff_reg[j] <= {in_sat[j][POS_W-1], in_sat[j]}
                                - {in_rx[j][POS_W-1], in_rx[j]};
                s1_vt_reg[j]   <= in_vel[j] * $signed({1'b0, lookahead_reg});
                s1_rx_reg[j]   <= in_rx[j];
                s2_los_reg[j]  <= los_next[j];
                s2_pre_reg[j]  <= pre_next[j];
                s2_rx_reg[j]   <= VW'(s1_rx_reg[j]);
            end
            s2_rxz_reg <= (s1_rx_reg[0] == '0) && (s1_rx_reg[1] == '0);
        end
    end

    // Normalisation of the longitude pilot, the receiver and both lines of sight.
    vec_t pil_i [2];
    vec_t pil_o [2];
    vec_t rec_o [3];
    vec_t los_o [3];
    vec_t pre_o [3];

    assign pil_i[0] = s2_rx_reg[0];
    assign pil_i[1] = s2_rx_reg[1];

    sae_norm #(.N(2)) u_norm_pil (.aclk(aclk), .adv(adv), .vec_i(pil_i),      .vec_o(pil_o));
    sae_norm #(.N(3)) u_norm_rec (.aclk(aclk), .adv(adv), .vec_i(s2_rx_reg),  .vec_o(rec_o));
    sae_norm #(.N(3)) u_norm_los (.aclk(aclk), .adv(adv), .vec_i(s2_los_reg), .vec_o(los_o));
    sae_norm #(.N(3)) u_norm_pre (.aclk(aclk), .adv(adv), .vec_i(s2_pre_reg), .vec_o(pre_o));

    // Valid and degenerate flags travel beside the normalisation stages.
    logic nf_valid_reg [3];
    logic nf_deg_reg   [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) nf_valid_reg[k] <= 1'b0;
        end else if (adv) begin
            nf_valid_reg[0] <= s2_valid_reg;
            nf_valid_reg[1] <= nf_valid_reg[0];
            nf_valid_reg[2] <= nf_valid_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nf_deg_reg[0] <= s2_rxz_reg || ((s2_pre_reg[0] == '0) && (s2_pre_reg[1] == '0)
                                            && (s2_pre_reg[2] == '0));
            nf_deg_reg[1] <= nf_deg_reg[0];
            nf_deg_reg[2] <= nf_deg_reg[1];
        end
    end

    // Longitude chain: index 0 is the half-turn flip, then one rotation a stage.
    logic lon_valid_reg [ITERS+1];
    logic lon_deg_reg   [ITERS+1];
    vec_t lon_px_reg [ITERS+1];
    vec_t lon_py_reg [ITERS+1];
    vec_t lon_cx_reg [ITERS+1];
    vec_t lon_cy_reg [ITERS+1];
    vec_t lon_cz_reg [ITERS+1];
    vec_t lon_lx_reg [ITERS+1];
    vec_t lon_ly_reg [ITERS+1];
    vec_t lon_lz_reg [ITERS+1];
    vec_t lon_qx_reg [ITERS+1];
    vec_t lon_qy_reg [ITERS+1];
    vec_t lon_qz_reg [ITERS+1];

    logic flip;
    assign flip = pil_o[0][VW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lon_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            lon_valid_reg[0] <= nf_valid_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lon_deg_reg[0] <= nf_deg_reg[2];
            lon_px_reg[0]  <= flip ? -pil_o[0] : pil_o[0];
            lon_py_reg[0]  <= flip ? -pil_o[1] : pil_o[1];
            lon_cx_reg[0]  <= flip ? -rec_o[0] : rec_o[0];
            lon_cy_reg[0]  <= flip ? -rec_o[1] : rec_o[1];
            lon_cz_reg[0]  <= rec_o[2];
            lon_lx_reg[0]  <= flip ? -los_o[0] : los_o[0];
            lon_ly_reg[0]  <= flip ? -los_o[1] : los_o[1];
            lon_lz_reg[0]  <= los_o[2];
            lon_qx_reg[0]  <= flip ? -pre_o[0] : pre_o[0];
            lon_qy_reg[0]  <= flip ? -pre_o[1] : pre_o[1];
            lon_qz_reg[0]  <= pre_o[2];
        end
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_lon
        logic cw;
        assign cw = !lon_py_reg[i][VW-1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                lon_valid_reg[i+1] <= 1'b0;
            end else if (adv) begin
                lon_valid_reg[i+1] <= lon_valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                lon_deg_reg[i+1] <= lon_deg_reg[i];
                lon_px_reg[i+1]  <= rot_x(lon_px_reg[i], lon_py_reg[i], i, cw);
                lon_py_reg[i+1]  <= rot_y(lon_px_reg[i], lon_py_reg[i], i, cw);
                lon_cx_reg[i+1]  <= rot_x(lon_cx_reg[i], lon_cy_reg[i], i, cw);
                lon_cy_reg[i+1]  <= rot_y(lon_cx_reg[i], lon_cy_reg[i], i, cw);
                lon_cz_reg[i+1]  <= lon_cz_reg[i];
                lon_lx_reg[i+1]  <= rot_x(lon_lx_reg[i], lon_ly_reg[i], i, cw);
                lon_ly_reg[i+1]  <= rot_y(lon_lx_reg[i], lon_ly_reg[i], i, cw);
                lon_lz_reg[i+1]  <= lon_lz_reg[i];
                lon_qx_reg[i+1]  <= rot_x(lon_qx_reg[i], lon_qy_reg[i], i, cw);
                lon_qy_reg[i+1]  <= rot_y(lon_qx_reg[i], lon_qy_reg[i], i, cw);
                lon_qz_reg[i+1]  <= lon_qz_reg[i];
            end
        end
    end

    // Latitude chain: index 0 applies gain matching to the z components, which did
    // not pass through the longitude rotation, and to the y components of both lines of sight.
    logic lat_valid_reg [ITERS+1];
    logic lat_deg_reg   [ITERS+1];
    vec_t lat_rh_reg [ITERS+1];
    vec_t lat_rz_reg [ITERS+1];
    vec_t lat_la_reg [ITERS+1];
    vec_t lat_lz_reg [ITERS+1];
    vec_t lat_le_reg [ITERS+1];
    vec_t lat_pa_reg [ITERS+1];
    vec_t lat_pz_reg [ITERS+1];
    vec_t lat_pe_reg [ITERS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            lat_valid_reg[0] <= lon_valid_reg[ITERS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lat_deg_reg[0] <= lon_deg_reg[ITERS];
            lat_rh_reg[0]  <= lon_cx_reg[ITERS];
            lat_rz_reg[0]  <= gain_k(lon_cz_reg[ITERS]);
            lat_la_reg[0]  <= lon_lx_reg[ITERS];
            lat_lz_reg[0]  <= gain_k(lon_lz_reg[ITERS]);
            lat_le_reg[0]  <= gain_k(lon_ly_reg[ITERS]);
            lat_pa_reg[0]  <= lon_qx_reg[ITERS];
            lat_pz_reg[0]  <= gain_k(lon_qz_reg[ITERS]);
            lat_pe_reg[0]  <= gain_k(lon_qy_reg[ITERS]);
        end
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_lat
        logic cw;
        assign cw = !lat_rz_reg[i][VW-1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                lat_valid_reg[i+1] <= 1'b0;
            end else if (adv) begin
                lat_valid_reg[i+1] <= lat_valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                lat_deg_reg[i+1] <= lat_deg_reg[i];
                lat_rh_reg[i+1]  <= rot_x(lat_rh_reg[i], lat_rz_reg[i], i, cw);
                lat_rz_reg[i+1]  <= rot_y(lat_rh_reg[i], lat_rz_reg[i], i, cw);
                lat_la_reg[i+1]  <= rot_x(lat_la_reg[i], lat_lz_reg[i], i, cw);
                lat_lz_reg[i+1]  <= rot_y(lat_la_reg[i], lat_lz_reg[i], i, cw);
                lat_le_reg[i+1]  <= lat_le_reg[i];
                lat_pa_reg[i+1]  <= rot_x(lat_pa_reg[i], lat_pz_reg[i], i, cw);
                lat_pz_reg[i+1]  <= rot_y(lat_pa_reg[i], lat_pz_reg[i], i, cw);
                lat_pe_reg[i+1]  <= lat_pe_reg[i];
            end
        end
    end

    // Middle chain: azimuth vectoring runs beside the rotation that folds the
    // predicted east component into the horizontal magnitude. Index 0 sets up
    // both into the right half-plane.
    logic mid_valid_reg [ITERS+1];
    logic mid_deg_reg   [ITERS+1];
    logic mid_azz_reg   [ITERS+1];
    vec_t mid_ax_reg [ITERS+1];
    vec_t mid_ay_reg [ITERS+1];
    ang_t mid_aa_reg [ITERS+1];
    vec_t mid_ez_reg [ITERS+1];
    vec_t mid_ee_reg [ITERS+1];
    vec_t mid_ey_reg [ITERS+1];

    logic az_neg;
    logic el_neg;
    assign az_neg = lat_lz_reg[ITERS][VW-1];
    assign el_neg = lat_pz_reg[ITERS][VW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            mid_valid_reg[0] <= lat_valid_reg[ITERS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mid_deg_reg[0] <= lat_deg_reg[ITERS];
            mid_azz_reg[0] <= (lat_lz_reg[ITERS] == '0) && (lat_le_reg[ITERS] == '0);
            mid_ax_reg[0]  <= az_neg ? -lat_lz_reg[ITERS] : lat_lz_reg[ITERS];
            mid_ay_reg[0]  <= az_neg ? -lat_le_reg[ITERS] : lat_le_reg[ITERS];
            mid_aa_reg[0]  <= az_neg ? ANG_HALF : '0;
            mid_ez_reg[0]  <= el_neg ? -lat_pz_reg[ITERS] : lat_pz_reg[ITERS];
            mid_ee_reg[0]  <= el_neg ? -lat_pe_reg[ITERS] : lat_pe_reg[ITERS];
            mid_ey_reg[0]  <= gain_k(lat_pa_reg[ITERS]);
        end
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_mid
        logic acw;
        logic ecw;
        assign acw = !mid_ay_reg[i][VW-1];
        assign ecw = !mid_ee_reg[i][VW-1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mid_valid_reg[i+1] <= 1'b0;
            end else if (adv) begin
                mid_valid_reg[i+1] <= mid_valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                mid_deg_reg[i+1] <= mid_deg_reg[i];
                mid_azz_reg[i+1] <= mid_azz_reg[i];
                mid_ax_reg[i+1]  <= rot_x(mid_ax_reg[i], mid_ay_reg[i], i, acw);
                mid_ay_reg[i+1]  <= rot_y(mid_ax_reg[i], mid_ay_reg[i], i, acw);
                mid_aa_reg[i+1]  <= acw ? mid_aa_reg[i] + ATAN_TBL[i]
                                        : mid_aa_reg[i] - ATAN_TBL[i];
                mid_ez_reg[i+1]  <= rot_x(mid_ez_reg[i], mid_ee_reg[i], i, ecw);
                mid_ee_reg[i+1]  <= rot_y(mid_ez_reg[i], mid_ee_reg[i], i, ecw);
                mid_ey_reg[i+1]  <= mid_ey_reg[i];
            end
        end
    end

    // Elevation chain: vectoring of (horizontal, up); the finished azimuth
    // rides along.
    logic        elv_valid_reg [ITERS+1];
    logic        elv_deg_reg   [ITERS+1];
    logic [31:0] elv_az_reg    [ITERS+1];
    vec_t        elv_x_reg     [ITERS+1];
    vec_t        elv_y_reg     [ITERS+1];
    ang_t        elv_a_reg     [ITERS+1];
    ang_t        az_turn;

    // The azimuth is taken modulo one turn before rounding.
    assign az_turn = {{(AW-TURN_FRAC){1'b0}}, mid_aa_reg[ITERS][TURN_FRAC-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            elv_valid_reg[0] <= mid_valid_reg[ITERS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            elv_deg_reg[0] <= mid_deg_reg[ITERS];
            elv_az_reg[0]  <= mid_azz_reg[ITERS] ? 32'd0 : to_output(az_turn);
            elv_x_reg[0]   <= mid_ez_reg[ITERS];
            elv_y_reg[0]   <= mid_ey_reg[ITERS];
            elv_a_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_elv
        logic cw;
        assign cw = !elv_y_reg[i][VW-1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                elv_valid_reg[i+1] <= 1'b0;
            end else if (adv) begin
                elv_valid_reg[i+1] <= elv_valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                elv_deg_reg[i+1] <= elv_deg_reg[i];
                elv_az_reg[i+1]  <= elv_az_reg[i];
                elv_x_reg[i+1]   <= rot_x(elv_x_reg[i], elv_y_reg[i], i, cw);
                elv_y_reg[i+1]   <= rot_y(elv_x_reg[i], elv_y_reg[i], i, cw);
                elv_a_reg[i+1]   <= cw ? elv_a_reg[i] + ATAN_TBL[i]
                                       : elv_a_reg[i] - ATAN_TBL[i];
            end
        end
    end

    // Output register: clamp to a quarter turn, round, and zero the angles of
    // a degenerate transaction.
    ang_t        el_clamp;
    logic        m_valid_reg;
    logic [31:0] m_el_reg;
    logic [31:0] m_az_reg;
    logic        m_deg_reg;

    always_comb begin
        el_clamp = elv_a_reg[ITERS];
        if (el_clamp > ANG_QTR)  el_clamp = ANG_QTR;
        if (el_clamp < -ANG_QTR) el_clamp = -ANG_QTR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= elv_valid_reg[ITERS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_deg_reg <= elv_deg_reg[ITERS];
            m_el_reg  <= elv_deg_reg[ITERS] ? 32'd0 : to_output(el_clamp);
            m_az_reg  <= elv_deg_reg[ITERS] ? 32'd0 : elv_az_reg[ITERS];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_az_reg, m_el_reg};
    assign m_axis_tuser  = m_deg_reg;

endmodule

FILE: rtl/sae_checker.sv
// Port-level checker for the azimuth and elevation block, bound to the top level.
`include "satellite_azimuth_elevation_top_macros.svh"

module sae_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [sae_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tuser
);
    import sae_pkg::*;

    // A held result stays unchanged until taken.
    `SAE_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // Input is taken whenever the output register is free.
    `SAE_ASSERT(a_in_ready, aclk, aresetn, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

    // A degenerate result carries zero angles.
    `SAE_ASSERT(a_deg_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "degenerate result with non-zero angles")

    // Elevation never leaves plus or minus a quarter turn.
    `SAE_ASSERT(a_el_range, aclk, aresetn, m_axis_tvalid |-> (!m_axis_tdata[31] && m_axis_tdata[31:0] <= 32'h4000_0000) || (m_axis_tdata[31] && m_axis_tdata[31:0] >= 32'hC000_0000), "elevation out of range")

    // Reset empties the pipeline.
    `SAE_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind satellite_azimuth_elevation_top sae_checker u_sae_checker (.*);

FILE: bench/satellite_azimuth_elevation_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each azimuth and elevation result from the accepted transactions and compares.
module satellite_azimuth_elevation_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sae_pkg::LOOK_W-1:0]        cfg_wr_data,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [sae_pkg::S_DATA_W-1:0]      s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [sae_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  logic                              m_axis_tuser,
    output int                                errors,
    output int                                pending
);
    import sae_pkg::*;

    typedef struct packed {
        logic [31:0] elevation;
        logic [31:0] azimuth;
        logic        degenerate;
    } angles_t;

    localparam int STEPS = 40;

    longint    atan_turns [STEPS];
    angles_t   angles_due [$];
    logic [7:0] look_s;

    initial begin
        longint unsigned sum, term;
        logic [127:0]    prod;
        int              e;
        atan_turns[0] = longint'(1) <<< 45;
        for (int i = 1; i < STEPS; i++) begin
            sum = 0;
            for (int k = 0; k < 32; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = (64'd1 << e) / 64'(2 * k + 1);
                    if (k % 2 == 1) sum = sum - term;
                    else            sum = sum + term;
                end
            end
            prod = {64'd0, sum} * {64'd0, INV_TWO_PI_Q64};
            atan_turns[i] = longint'(prod[127:64] >> 14);
        end
    end

    // Scales the first n components so that the largest magnitude sits in [2^28, 2^29).
    function automatic void scale_block(ref longint v[3], input int n);
        longint unsigned m, a;
        int              top;
        m = 0;
        for (int j = 0; j < n; j++) begin
            a = v[j] < 0 ? unsigned'(-v[j]) : unsigned'(v[j]);
            if (a > m) m = a;
        end
        if (m == 0) return;
        top = 0;
        while (top < 63 && (m >> (top + 1)) != 0) top++;
        for (int j = 0; j < n; j++) begin
            if (top < 28)      v[j] = v[j] <<< (28 - top);
            else if (top > 28) v[j] = v[j] >>> (top - 28);
        end
    endfunction

    function automatic void turn(ref longint a, ref longint b, input int i, input bit cw);
        longint x, y;
        x = a;
        y = b;
        if (cw) begin
            a = x + (y >>> i);
            b = y - (x >>> i);
        end else begin
            a = x - (y >>> i);
            b = y + (x >>> i);
        end
    endfunction

    function automatic longint gain_match(longint v);
        return (v * 64'sd1768195363 + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic longint angle_of(longint x, longint y);
        longint acc;
        bit     cw;
        acc = 0;
        for (int i = 0; i < STEPS; i++) begin
            cw = y >= 0;
            turn(x, y, i, cw);
            acc += cw ? atan_turns[i] : -atan_turns[i];
        end
        return acc;
    endfunction

    function automatic logic [31:0] to_units(longint a);
        longint r;
        r = ((a + (longint'(1) <<< 15)) >>> 16) <<< 16;
        r = (r + (longint'(1) <<< 15)) >>> 16;
        return r[31:0];
    endfunction

    function automatic angles_t predict_angles(logic [S_DATA_W-1:0] d, logic [7:0] look);
        angles_t res;
        longint  sat[3], vel[3], rx[3], los[3], pre[3], rec[3], pil[3];
        longint  rh, rz, la, lz, le, pa, pz, pe, acc, base;
        bit      cw;
        for (int j = 0; j < 3; j++) begin
            sat[j] = longint'($signed(d[j*34 +: 34]));
            vel[j] = longint'($signed(d[102 + j*25 +: 25]));
            rx[j]  = longint'($signed(d[177 + j*34 +: 34]));
        end
        res = '0;
        if (rx[0] == 0 && rx[1] == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        for (int j = 0; j < 3; j++) begin
            los[j] = (sat[j] - rx[j]) * 10;
            pre[j] = los[j] + vel[j] * longint'(look);
            rec[j] = rx[j];
        end
        if (pre[0] == 0 && pre[1] == 0 && pre[2] == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        pil[0] = rx[0];
        pil[1] = rx[1];
        pil[2] = 0;
        scale_block(pil, 2);
        scale_block(rec, 3);
        scale_block(los, 3);
        scale_block(pre, 3);

        // Longitude: bring the receiver's equatorial direction onto the x axis.
        if (pil[0] < 0) begin
            for (int j = 0; j < 2; j++) begin
                pil[j] = -pil[j];
                rec[j] = -rec[j];
                los[j] = -los[j];
                pre[j] = -pre[j];
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            cw = pil[1] >= 0;
            turn(pil[0], pil[1], i, cw);
            turn(rec[0], rec[1], i, cw);
            turn(los[0], los[1], i, cw);
            turn(pre[0], pre[1], i, cw);
        end

        // Latitude: bring the receiver onto local up.
        rh = rec[0];
        rz = gain_match(rec[2]);
        la = los[0];
        lz = gain_match(los[2]);
        le = gain_match(los[1]);
        pa = pre[0];
        pz = gain_match(pre[2]);
        pe = gain_match(pre[1]);
        for (int i = 0; i < STEPS; i++) begin
            cw = rz >= 0;
            turn(rh, rz, i, cw);
            turn(la, lz, i, cw);
            turn(pa, pz, i, cw);
        end

        if (!(lz == 0 && le == 0)) begin
            base = 0;
            if (lz < 0) begin
                lz = -lz;
                le = -le;
                base = longint'(1) <<< 47;
            end
            acc = (base + angle_of(lz, le)) & ((longint'(1) <<< 48) - 1);
            res.azimuth = to_units(acc);
        end

        if (pz < 0) begin
            pz = -pz;
            pe = -pe;
        end
        for (int i = 0; i < STEPS; i++) turn(pz, pe, i, pe >= 0);
        acc = angle_of(pz, gain_match(pa));
        if (acc > (longint'(1) <<< 46))  acc = longint'(1) <<< 46;
        if (acc < -(longint'(1) <<< 46)) acc = -(longint'(1) <<< 46);
        res.elevation = to_units(acc);
        return res;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch in %s: got %0h, expected %0h", field, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        angles_t want;
        if (!aresetn) begin
            look_s = LOOK_RESET;
            angles_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (angles_due.size() == 0) begin
                    $display("result transaction arrived with none outstanding");
                    errors++;
                end else begin
                    want = angles_due.pop_front();
                    if (m_axis_tdata[31:0] !== want.elevation)
                        report("elevation", m_axis_tdata[31:0], want.elevation);
                    if (m_axis_tdata[63:32] !== want.azimuth)
                        report("azimuth", m_axis_tdata[63:32], want.azimuth);
                    if (m_axis_tuser !== want.degenerate)
                        report("degenerate", m_axis_tuser, want.degenerate);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                angles_due.push_back(predict_angles(s_axis_tdata, look_s));
            if (cfg_wr_en) look_s = cfg_wr_data;
        end
        pending = angles_due.size();
    end

endmodule

FILE: bench/satellite_azimuth_elevation_top_test.sv
`timescale 1ns / 1ps
// Top of the azimuth and elevation testbench: clock, reset, stimulus, back-pressure and verdict.
module satellite_azimuth_elevation_top_test;
    import sae_pkg::*;

    // Settling waits use a margin over the block's path from input to output.
    localparam int SETTLE    = 220;
    localparam int CYCLE_CAP = 600000;
    localparam longint POS_MAX = 64'sd5000000000;
    localparam longint VEL_MAX = 64'sd10000000;

    typedef struct {
        longint sat[3];
        longint vel[3];
        longint rx[3];
    } sighting_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [LOOK_W-1:0]     cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // sat_x, sat_y, sat_z, sat_vx, sat_vy, sat_vz, rx_x, rx_y, rx_z, zero pad
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // elevation, azimuth
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // degenerate
    logic                  m_axis_tuser;

    int                    errors;
    int                    pending;
    int                    cycles;
    int                    burst_left;
    logic [7:0]            look_now;

    satellite_azimuth_elevation_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    satellite_azimuth_elevation_checker angles_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // The run is abandoned if it goes on far longer than the slowest correct run could.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver alternates between stretches of full readiness and stretches
    // where it stalls at random, so back-pressure meets every stage of the pipeline.
    int stall_mode;
    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
            stall_left    <= 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(10, 300);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    m_axis_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    function automatic longint pick(longint lo, longint hi);
        longint unsigned span;
        span = unsigned'(hi - lo) + 64'd1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    function automatic logic [S_DATA_W-1:0] pack(sighting_t s);
        logic [S_DATA_W-1:0] d;
        d = '0;
        for (int j = 0; j < 3; j++) begin
            d[j*34 +: 34]       = s.sat[j][33:0];
            d[102 + j*25 +: 25] = s.vel[j][24:0];
            d[177 + j*34 +: 34] = s.rx[j][33:0];
        end
        return d;
    endfunction

    // A receiver near the Earth's surface and a satellite in a plausible orbit.
    function automatic sighting_t plausible_pass();
        sighting_t s;
        for (int j = 0; j < 3; j++) begin
            s.rx[j]  = pick(-64'sd640000000, 64'sd640000000);
            s.sat[j] = pick(-64'sd2700000000, 64'sd2700000000);
            s.vel[j] = pick(-64'sd4000000, 64'sd4000000);
        end
        return s;
    endfunction

    // Anything the fields allow, with small magnitudes and exact zeros mixed in.
    function automatic sighting_t noise_sighting();
        sighting_t s;
        for (int j = 0; j < 3; j++) begin
            case ($urandom_range(0, 3))
                0: s.rx[j] = 0;
                1: s.rx[j] = pick(-64'sd1000, 64'sd1000);
                default: s.rx[j] = pick(-POS_MAX, POS_MAX);
            endcase
            s.sat[j] = $urandom_range(0, 4) == 0 ? s.rx[j] : pick(-POS_MAX, POS_MAX);
            s.vel[j] = $urandom_range(0, 3) == 0 ? 0 : pick(-VEL_MAX, VEL_MAX);
        end
        return s;
    endfunction

    function automatic sighting_t make(longint sx, longint sy, longint sz,
                                       longint vx, longint vy, longint vz,
                                       longint rx, longint ry, longint rz);
        sighting_t s;
        s.sat = '{sx, sy, sz};
        s.vel = '{vx, vy, vz};
        s.rx  = '{rx, ry, rz};
        return s;
    endfunction

    // Offers one transaction and returns once it has been accepted. Each burst
    // ends in a gap with valid low, so valid never drops and rises in one step.
    task automatic offer(sighting_t s);
        logic took;
        s_axis_tdata  <= pack(s);
        s_axis_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            took = s_axis_tready;
            @(posedge aclk);
        end while (!took);
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(100, 250)
                                                   : $urandom_range(1, 20);
        end
    endtask

    // Registers are written only with the pipeline drained and settled.
    task automatic set_lookahead(logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        look_now = v;
    endtask

    task automatic random_phase(int count);
        sighting_t s;
        longint    d;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0: begin
                    // Predicted line of sight cancels exactly when the lookahead allows it.
                    s = plausible_pass();
                    if (look_now != 0) begin
                        for (int j = 0; j < 3; j++) begin
                            s.vel[j] = pick(-64'sd400000, 64'sd400000);
                            d = -(s.vel[j] * longint'(look_now));
                            if (d % 10 != 0) begin
                                s.vel[j] = 0;
                                d = 0;
                            end
                            s.sat[j] = s.rx[j] + d / 10;
                        end
                    end
                end
                1: begin
                    s = plausible_pass();
                    s.rx[0] = 0;
                    s.rx[1] = $urandom_range(0, 1) ? 0 : pick(-64'sd3, 64'sd3);
                end
                2: begin
                    s = plausible_pass();
                    s.sat = s.rx;
                end
                3, 4, 5: s = noise_sighting();
                default: s = plausible_pass();
            endcase
            offer(s);
        end
    endtask

    initial begin
        sighting_t dir [$];
        logic [7:0] look_plan [6];
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        burst_left    = 5;
        look_now      = LOOK_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cases, run with the lookahead left at its reset value.
        dir.push_back(make(64'sd2600000000, 0, 0, 1000, 0, 0, 0, 0, 635000000)); // polar axis
        dir.push_back(make(64'sd2600000000, 5, 7, 0, 0, 0, 0, 0, 0));  // receiver at origin
        dir.push_back(make(640000000, 1, 2, 0, 0, 0, 640000000, 1, 2));        // no line of sight
        dir.push_back(make(642000000, 3000000, -1000000, -1000000, -1500000, 500000,
                           640000000, 0, 0));                                  // prediction cancels
        dir.push_back(make(640000000, 0, 0, 30000, -20000, 10000, 640000000, 0, 0)); // sat on receiver
        dir.push_back(make(64'sd2600000000, 0, 0, 0, 0, 0, 1, 0, 635000000));  // next to the pole
        dir.push_back(make(0, -64'sd2600000000, 100, 0, 0, 0, 0, -1, -635000000));
        dir.push_back(make(POS_MAX, POS_MAX, POS_MAX, VEL_MAX, VEL_MAX, VEL_MAX,
                           -POS_MAX, -POS_MAX, -POS_MAX));
        dir.push_back(make(-POS_MAX, -POS_MAX, -POS_MAX, -VEL_MAX, -VEL_MAX, -VEL_MAX,
                           POS_MAX, POS_MAX, POS_MAX));
        dir.push_back(make(64'sd2600000000, 0, 0, 0, 0, 0, 640000000, 0, 0));  // overhead
        dir.push_back(make(-2000000000, 0, 0, 0, 0, 0, 640000000, 0, 0));      // nadir
        dir.push_back(make(740000000, -1, 1000000000, 0, 0, 0, 640000000, 0, 0)); // just west of north
        dir.push_back(make(740000000, 0, -1000000000, 0, 0, 0, 640000000, 0, 0)); // due south
        dir.push_back(make(740000000, 900000000, 0, 0, 0, 0, 640000000, 0, 0));   // due east
        dir.push_back(make(-POS_MAX, 1, -1, 1, -1, 0, 1, -1, 1));
        foreach (dir[i]) offer(dir[i]);

        look_plan = '{8'd0, 8'd255, 8'd1, 8'd20, 8'd0, 8'd0};
        look_plan[4] = 8'($urandom_range(2, 254));
        look_plan[5] = 8'($urandom_range(2, 254));
        random_phase(200);
        foreach (look_plan[p]) begin
            set_lookahead(look_plan[p]);
            random_phase(170);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
